// File: sv/baseband_link_arq_defines.svh
// Assertion macros shared by the link ARQ RTL.
// Included by the modules that check their own logic; empty under SYNTHESIS.
`ifndef BASEBAND_LINK_ARQ_DEFINES_SVH
`define BASEBAND_LINK_ARQ_DEFINES_SVH

`ifndef SYNTHESIS
`define BBARQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BBARQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BBARQ_ASSERT(lbl, prop, msg)
`define BBARQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/bbarq_pkg.sv
// Types and constants for the baseband link ARQ block.
// No dependencies; used by bbarq_engine and baseband_link_arq.
`timescale 1ns / 1ps

package bbarq_pkg;

	localparam int CLOCK_BITS = 28;
	localparam int TICK_BITS  = 24;

	localparam logic [1:0] CMD_RX    = 2'd0;
	localparam logic [1:0] CMD_TX    = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_POLL = 2'd1;
	localparam logic [1:0] KIND_NULL = 2'd2;

	localparam logic [1:0] ST_NONE    = 2'd0;
	localparam logic [1:0] ST_TX      = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	localparam logic [1:0] REG_MASTER_ROLE = 2'd0;
	localparam logic [1:0] REG_OWN_LT_ADDR = 2'd1;
	localparam logic [1:0] REG_SUPERVISION = 2'd2;

	localparam logic [TICK_BITS-1:0] SUPERVISION_RESET = TICK_BITS'(3200);

	typedef struct packed {
		logic                  master_role;
		logic [2:0]            own_lt_addr;
		logic [TICK_BITS-1:0]  supervision_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]            command;
		logic [CLOCK_BITS-1:0] now_clock;
		logic                  has_header;
		logic                  has_crc;
		logic                  crc_good;
		logic [2:0]            rx_lt_addr;
		logic                  rx_arqn;
		logic                  rx_seqn;
		logic                  rx_is_poll;
		logic                  queue_has_packet;
	} item_t;

	typedef struct packed {
		logic [1:0] rx_status;
		logic       deliver_payload;
		logic       connected_event;
		logic       release_tx;
		logic       take_from_queue;
		logic [1:0] tx_kind;
		logic       tx_arqn;
		logic       tx_seqn;
	} result_t;

	typedef struct packed {
		logic                  local_seq;
		logic                  remote_seq;
		logic                  ack_pending;
		logic                  link_up;
		logic                  tx_in_flight;
		logic [CLOCK_BITS-1:0] last_rx_clock;
	} link_t;

	localparam link_t LINK_RESET = '{
		local_seq:     1'b1,
		remote_seq:    1'b1,
		ack_pending:   1'b0,
		link_up:       1'b0,
		tx_in_flight:  1'b0,
		last_rx_clock: '0
	};

endpackage

// File: sv/bbarq_engine.sv
// Link state and per-command ARQ decision logic.
// Depends on bbarq_pkg and baseband_link_arq_defines.svh.
`timescale 1ns / 1ps
`include "baseband_link_arq_defines.svh"

module bbarq_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  bbarq_pkg::cfg_t    cfg,
	input  bbarq_pkg::item_t   item,
	input  logic              fire,
	output bbarq_pkg::result_t result
);
	import bbarq_pkg::*;

	link_t                 state_q;
	link_t                 state_d;
	logic [CLOCK_BITS-1:0] elapsed;
	logic                  timeout;
	logic                  addr_ok;

	assign elapsed = item.now_clock - state_q.last_rx_clock;
	assign timeout = elapsed > CLOCK_BITS'(cfg.supervision_ticks);
	assign addr_ok = cfg.master_role || (item.rx_lt_addr == cfg.own_lt_addr);

	always_comb begin
		state_d = state_q;
		result  = '0;
		case (item.command)
			CMD_RX: begin
				result.rx_status = cfg.master_role ? ST_TX : ST_NONE;
				if (!item.has_header) begin
					if (timeout) begin
						result.rx_status = ST_TIMEOUT;
					end
				end else begin
					if (!state_q.link_up) begin
						state_d.link_up        = 1'b1;
						result.connected_event = 1'b1;
					end
					state_d.last_rx_clock = item.now_clock;
					if (addr_ok) begin
						if (item.rx_arqn && state_q.tx_in_flight) begin
							state_d.tx_in_flight = 1'b0;
							state_d.local_seq    = ~state_q.local_seq;
							result.release_tx    = 1'b1;
						end
						if (item.has_crc) begin
							if (item.rx_seqn != state_q.remote_seq) begin
								state_d.ack_pending = 1'b1;
							end else if (item.crc_good) begin
								result.deliver_payload = 1'b1;
								state_d.remote_seq     = ~state_q.remote_seq;
								state_d.ack_pending    = 1'b1;
							end
						end
						if (cfg.master_role || item.rx_is_poll || state_d.ack_pending) begin
							result.rx_status = ST_TX;
						end
					end
				end
			end
			CMD_TX: begin
				if (!state_q.tx_in_flight && item.queue_has_packet) begin
					state_d.tx_in_flight   = 1'b1;
					result.take_from_queue = 1'b1;
				end
				if (state_d.tx_in_flight) begin
					result.tx_kind = KIND_DATA;
				end else begin
					result.tx_kind = cfg.master_role ? KIND_POLL : KIND_NULL;
				end
				result.tx_arqn      = state_q.ack_pending;
				result.tx_seqn      = state_q.local_seq;
				state_d.ack_pending = 1'b0;
			end
			CMD_START: begin
				state_d               = LINK_RESET;
				state_d.last_rx_clock = item.now_clock;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LINK_RESET;
		end else if (fire) begin
			state_q <= state_d;
		end
	end

	`BBARQ_ASSERT(a_release_needs_flight, fire && result.release_tx |-> state_q.tx_in_flight,
		"release without packet in flight")
	`BBARQ_ASSERT_NEXT(a_take_sets_flight, fire && result.take_from_queue,
		state_q.tx_in_flight, "dequeue did not mark packet in flight")
	`BBARQ_ASSERT_NEXT(a_deliver_sets_ack, fire && result.deliver_payload,
		state_q.ack_pending, "delivered packet left no pending ack")
	`BBARQ_ASSERT_NEXT(a_start_clears, fire && item.command == CMD_START,
		!state_q.link_up && !state_q.tx_in_flight && state_q.local_seq && state_q.remote_seq,
		"start did not clear link state")

endmodule

// File: sv/baseband_link_arq.sv
// Path: from input transfer to result transfer via the input register, then the result register.
// Throughput: one command per cycle unless the output stalls; the link state updates once per command.
// Stalls: ready drops only when both the input and result registers hold unaccepted data.
// Reset: arst_n clears the link state, config registers (supervision 3200 ticks) and valids.
// Top level: stream handshake, config registers; depends on bbarq_pkg and bbarq_engine.
`timescale 1ns / 1ps
`include "baseband_link_arq_defines.svh"

module baseband_link_arq (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [27:0] now_clock, [28] has_header, [29] has_crc, [30] crc_good,
	// [33:31] rx_lt_addr, [34] rx_arqn, [35] rx_seqn, [36] rx_is_poll,
	// [37] queue_has_packet, [39:38] zero
	input  logic [39:0] s_axis_tdata,
	// [1:0] command
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] rx_status, [2] deliver_payload, [3] connected_event, [4] release_tx,
	// [5] take_from_queue, [6] tx_arqn, [7] tx_seqn
	output logic [7:0]  m_axis_tdata,
	// [1:0] tx_kind
	output logic [1:0]  m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import bbarq_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	logic    out_valid_q;
	result_t result;
	result_t out_q;
	logic    advance;
	logic    s_fire;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_role       <= 1'b0;
			cfg_q.own_lt_addr       <= 3'd0;
			cfg_q.supervision_ticks <= SUPERVISION_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MASTER_ROLE: cfg_q.master_role       <= cfg_data[0];
				REG_OWN_LT_ADDR: cfg_q.own_lt_addr       <= cfg_data[2:0];
				REG_SUPERVISION: cfg_q.supervision_ticks <= cfg_data[TICK_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1.command          <= s_axis_tuser;
			item_s1.now_clock        <= s_axis_tdata[CLOCK_BITS-1:0];
			item_s1.has_header       <= s_axis_tdata[28];
			item_s1.has_crc          <= s_axis_tdata[29];
			item_s1.crc_good         <= s_axis_tdata[30];
			item_s1.rx_lt_addr       <= s_axis_tdata[33:31];
			item_s1.rx_arqn          <= s_axis_tdata[34];
			item_s1.rx_seqn          <= s_axis_tdata[35];
			item_s1.rx_is_poll       <= s_axis_tdata[36];
			item_s1.queue_has_packet <= s_axis_tdata[37];
		end
		if (advance) begin
			out_q <= result;
		end
	end

	bbarq_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item_s1),
		.fire   (advance),
		.result (result)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.tx_seqn, out_q.tx_arqn, out_q.take_from_queue,
		out_q.release_tx, out_q.connected_event, out_q.deliver_payload, out_q.rx_status};
	assign m_axis_tuser  = out_q.tx_kind;

	`BBARQ_ASSERT_NEXT(a_stalled_item_kept, valid_s1 && out_valid_q && !m_axis_tready,
		valid_s1 && $stable(item_s1), "stalled command lost or changed")
	`BBARQ_ASSERT(a_no_overrun, s_fire |-> !valid_s1 || advance,
		"input taken over a held command")

endmodule
